### rtl/mcq_pkg.sv
// Shared types and constants for the multi-class two-priority queue.
// Used by mcq_ctrl, mcq_datapath and multi_class_two_priority_queue_core.
package mcq_pkg;

   // Default configuration of the core.
   localparam int NUM_CLASSES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int TAG_BITS_DEF    = 16;

   // Fixed widths of the port fields.
   localparam int CLASS_W = 4;
   localparam int TAG_W   = 16;
   localparam int OCC_W   = 4;
   localparam int STAT_W  = 2;

   // Request operation codes.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SERVE  = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_SERVED   = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the accepted request
      logic exec;     // decide, update the queue and fill the result
      logic capture;  // take the tag read from the entry store
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic read_pending;  // the current request pops an entry
   } sts_type;

endpackage

### rtl/mcq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module mcq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/mcq_ctrl.sv
// Sequencing controller of the queue core: accept, execute, read, respond.
// Depends on mcq_pkg for the command and status structs.
module mcq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  mcq_pkg::sts_type sts,
   output mcq_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = sts.read_pending ? S_READ : S_OUT;
         end
         S_READ: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_OUT);
   assign cmd.load    = (state_ff == S_IDLE) && req_valid;
   assign cmd.exec    = (state_ff == S_EXEC);
   assign cmd.capture = (state_ff == S_READ);

endmodule

### rtl/mcq_datapath.sv
// Datapath of the queue core: per-class counts and head pointers, the shared
// entry store and the result registers. Depends on mcq_pkg and mcq_ram.
module mcq_datapath #(
   parameter int NUM_CLASSES = mcq_pkg::NUM_CLASSES_DEF,
   parameter int QUEUE_DEPTH = mcq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = mcq_pkg::TAG_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mcq_pkg::cmd_type              cmd,
   output mcq_pkg::sts_type              sts,
   input  logic                          req_func,
   input  logic [mcq_pkg::CLASS_W-1:0]   req_class_index,
   input  logic [mcq_pkg::TAG_W-1:0]     req_item_tag,
   input  logic                          req_urgent,
   output logic [mcq_pkg::STAT_W-1:0]    rsp_status,
   output logic [mcq_pkg::TAG_W-1:0]     rsp_served_tag,
   output logic [mcq_pkg::OCC_W-1:0]     rsp_occupancy
);

   localparam int CLS_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRIES  = NUM_CLASSES * QUEUE_DEPTH;
   localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int STORE_W  = (TAG_BITS < mcq_pkg::TAG_W) ? TAG_BITS : mcq_pkg::TAG_W;
   localparam int WIDE_W   = CLS_W + mcq_pkg::CLASS_W;

   // Captured request.
   logic                        func_ff;
   logic [mcq_pkg::CLASS_W-1:0] class_ff;
   logic [mcq_pkg::TAG_W-1:0]   tag_ff;
   logic                        urgent_ff;

   // Each queue is a ring in its own slice of the entry store.
   logic [CNT_W-1:0]  count_ff [NUM_CLASSES];
   logic [SLOT_W-1:0] head_ff  [NUM_CLASSES];

   logic [mcq_pkg::STAT_W-1:0] status_ff;
   logic [mcq_pkg::TAG_W-1:0]  served_ff;
   logic [mcq_pkg::OCC_W-1:0]  occ_ff;

   logic [WIDE_W-1:0]          cls_wide;
   logic [CLS_W-1:0]           cls_sel;
   logic                       cls_ok;
   logic [CNT_W-1:0]           cur_cnt;
   logic [SLOT_W-1:0]          cur_head;
   logic                       is_full;
   logic                       is_empty;
   logic [SLOT_W-1:0]          head_dec;
   logic [SLOT_W-1:0]          head_inc;
   logic [SLOT_W:0]            tail_sum;
   logic [SLOT_W-1:0]          tail_slot;
   logic [SLOT_W-1:0]          ins_slot;
   logic [SLOT_W-1:0]          acc_slot;
   logic                       do_insert;
   logic                       do_pop;
   logic [CNT_W-1:0]           new_cnt;
   logic [mcq_pkg::STAT_W-1:0] new_status;
   logic [ADDR_W-1:0]          ram_addr;
   logic [STORE_W-1:0]         ram_rdata;

   assign cls_wide = {{CLS_W{1'b0}}, class_ff};
   assign cls_sel  = cls_wide[CLS_W-1:0];
   assign cls_ok   = cls_wide < WIDE_W'(NUM_CLASSES);
   assign cur_cnt  = count_ff[cls_sel];
   assign cur_head = head_ff[cls_sel];
   assign is_full  = (cur_cnt == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (cur_cnt == '0);

   assign head_dec  = (cur_head == '0) ? SLOT_W'(QUEUE_DEPTH - 1) : cur_head - 1'b1;
   assign head_inc  = (cur_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
   assign tail_sum  = {1'b0, cur_head} + (SLOT_W + 1)'(cur_cnt);
   assign tail_slot = (tail_sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) ?
                      SLOT_W'(tail_sum - (SLOT_W + 1)'(QUEUE_DEPTH)) : tail_sum[SLOT_W-1:0];
   assign ins_slot  = urgent_ff ? head_dec : tail_slot;

   assign do_insert = cmd.exec && cls_ok && (func_ff == mcq_pkg::FUNC_INSERT) && !is_full;
   assign do_pop    = cmd.exec && cls_ok && (func_ff == mcq_pkg::FUNC_SERVE) && !is_empty;
   assign sts.read_pending = cls_ok && (func_ff == mcq_pkg::FUNC_SERVE) && !is_empty;

   // A pop reads the head slot; an insert writes the new slot.
   assign acc_slot = do_insert ? ins_slot : cur_head;
   assign ram_addr = ADDR_W'(cls_sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(acc_slot);

   always_comb begin
      new_cnt = cur_cnt;
      if (do_insert) begin
         new_cnt = cur_cnt + 1'b1;
      end else if (do_pop) begin
         new_cnt = cur_cnt - 1'b1;
      end
   end

   always_comb begin
      if (!cls_ok) begin
         new_status = (func_ff == mcq_pkg::FUNC_SERVE) ? mcq_pkg::ST_EMPTY : mcq_pkg::ST_FULL;
      end else if (func_ff == mcq_pkg::FUNC_INSERT) begin
         new_status = is_full ? mcq_pkg::ST_FULL : mcq_pkg::ST_INSERTED;
      end else begin
         new_status = is_empty ? mcq_pkg::ST_EMPTY : mcq_pkg::ST_SERVED;
      end
   end

   mcq_ram #(
      .WIDTH (STORE_W),
      .DEPTH (ENTRIES)
   ) u_entry_store (
      .clock (clock),
      .we    (do_insert),
      .addr  (ram_addr),
      .wdata (tag_ff[STORE_W-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_func;
         class_ff  <= req_class_index;
         tag_ff    <= req_item_tag;
         urgent_ff <= req_urgent;
      end
      if (cmd.exec) begin
         status_ff <= new_status;
         served_ff <= '0;
         occ_ff    <= cls_ok ? mcq_pkg::OCC_W'(new_cnt) : '0;
      end
      if (cmd.capture) begin
         served_ff <= mcq_pkg::TAG_W'(ram_rdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CLASSES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else begin
         if (do_insert || do_pop) begin
            count_ff[cls_sel] <= new_cnt;
         end
         if (do_insert && urgent_ff) begin
            head_ff[cls_sel] <= head_dec;
         end else if (do_pop) begin
            head_ff[cls_sel] <= head_inc;
         end
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_served_tag = served_ff;
   assign rsp_occupancy  = occ_ff;

endmodule

### rtl/multi_class_two_priority_queue_core.sv
// Each request is accepted only when the core is idle. An insert, a refusal or an
// empty serve goes through the execute state to its result; a serve of a non-empty
// queue also goes through a read state, for the registered read of the single-port
// entry store. The core is ready again in the cycle after the result is taken.
// Each class queue is a ring with its own head pointer and count, so head
// insertion and removal move no entries. Counts clear at reset.
// Depends on mcq_pkg, mcq_ctrl, mcq_datapath and mcq_ram.
module multi_class_two_priority_queue_core #(
   parameter int NUM_CLASSES = mcq_pkg::NUM_CLASSES_DEF,
   parameter int QUEUE_DEPTH = mcq_pkg::QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = mcq_pkg::TAG_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [mcq_pkg::CLASS_W-1:0] req_class_index,
   input  logic [mcq_pkg::TAG_W-1:0]   req_item_tag,
   input  logic                        req_urgent,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [mcq_pkg::STAT_W-1:0]  rsp_status,
   output logic [mcq_pkg::TAG_W-1:0]   rsp_served_tag,
   output logic [mcq_pkg::OCC_W-1:0]   rsp_occupancy
);

   mcq_pkg::cmd_type cmd;
   mcq_pkg::sts_type sts;

   mcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mcq_datapath #(
      .NUM_CLASSES (NUM_CLASSES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_class_index (req_class_index),
      .req_item_tag    (req_item_tag),
      .req_urgent      (req_urgent),
      .rsp_status      (rsp_status),
      .rsp_served_tag  (rsp_served_tag),
      .rsp_occupancy   (rsp_occupancy)
   );

   // Only one item is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a result is pending");

   a_ready_drops: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("core still ready after accepting an item");

   a_tag_only_served: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != mcq_pkg::ST_SERVED) |-> (rsp_served_tag == '0))
      else $error("tag reported on a result that served nothing");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mcq_pkg::ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty result with non-zero occupancy");

endmodule
